/* sv/hlbc_pkg.sv */
// Package for the hashed LRU buffer cache: sizes, codes, command and status types,
// and the reset images of the bucket link lists. No dependencies.
package hlbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;
  localparam int NODE_COUNT  = NUM_BUFFERS + NUM_BUCKETS;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int SLOT_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int BLK_W       = 32;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Bucket hash for NUM_BUCKETS = 13: 2^12 mod 13 is 1, so fold the block number
  // into 12-bit chunks, then take the remainder of the sum by reciprocal multiply.
  localparam int MOD_FOLD   = 12;
  localparam int MOD_W      = 14;
  localparam int MOD_SHIFT  = 18;
  localparam int MOD_PROD_W = 29;
  localparam int MOD_Q_W    = MOD_PROD_W - MOD_SHIFT;
  localparam logic [MOD_PROD_W-1:0] MOD_RECIP = 29'd20165;
  localparam logic [1:0] MOD_LAST = 2'd2;

  localparam logic [1:0] FN_GET   = 2'd0;
  localparam logic [1:0] FN_REL   = 2'd1;
  localparam logic [1:0] FN_PIN   = 2'd2;
  localparam logic [1:0] FN_UNPIN = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef logic [NODE_W-1:0] node_t;
  typedef node_t [NODE_COUNT-1:0] node_tab_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [BKT_W-1:0] key_t;
  typedef logic [BKT_W:0] bkt_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MOD,
    CMD_HIT_START,
    CMD_HIT_STEP,
    CMD_HIT_DONE,
    CMD_FREE_START,
    CMD_FREE_STEP,
    CMD_FOUND,
    CMD_BKT_NEXT,
    CMD_FAIL,
    CMD_MV_RD,
    CMD_DETACH,
    CMD_POS_RD,
    CMD_POS_CAP,
    CMD_REL_POS,
    CMD_INS1,
    CMD_INS2,
    CMD_FILL,
    CMD_SLOT,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic in_get;
    logic is_get;
    logic is_rel;
    logic slot_ok;
    logic slot_rc_one;
    logic mod_last;
    logic hit_head;
    logic hit_match;
    logic free_head;
    logic free_ok;
    logic steal;
    logic bkt_end;
    logic bkt_is_key;
    logic out_free;
  } dp_stat_t;

  function automatic node_tab_t init_next();
    node_tab_t t;
    int k;
    for (int h = 0; h < NUM_BUCKETS; h++) t[NUM_BUFFERS + h] = node_t'(NUM_BUFFERS + h);
    k = 0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      t[i] = (i >= NUM_BUCKETS) ? node_t'(i - NUM_BUCKETS) : node_t'(NUM_BUFFERS + k);
      t[NUM_BUFFERS + k] = node_t'(i);
      k = (k == NUM_BUCKETS - 1) ? 0 : k + 1;
    end
    return t;
  endfunction

  function automatic node_tab_t init_prev();
    node_tab_t t;
    int k;
    for (int h = 0; h < NUM_BUCKETS; h++) t[NUM_BUFFERS + h] = node_t'(NUM_BUFFERS + h);
    k = 0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      t[i] = (i + NUM_BUCKETS < NUM_BUFFERS) ? node_t'(i + NUM_BUCKETS)
                                             : node_t'(NUM_BUFFERS + k);
      if (i < NUM_BUCKETS) t[NUM_BUFFERS + k] = node_t'(i);
      k = (k == NUM_BUCKETS - 1) ? 0 : k + 1;
    end
    return t;
  endfunction

  localparam node_tab_t INIT_NEXT = init_next();
  localparam node_tab_t INIT_PREV = init_prev();

endpackage

/* sv/hlbc_req_if.sv */
// Request channel of the buffer cache: valid/ready handshake and one request item.
// Depends on nothing.
interface hlbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  device_id;
  logic [31:0] block_number;
  logic [4:0]  buffer_slot;

  modport source (output valid, func, device_id, block_number, buffer_slot, input ready);
  modport sink (input valid, func, device_id, block_number, buffer_slot, output ready);
endinterface

/* sv/hlbc_rsp_if.sv */
// Response channel of the buffer cache: valid/ready handshake and one result item.
// Depends on nothing.
interface hlbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot_out;
  logic       was_hit;
  logic       needs_read;

  modport source (output valid, status, slot_out, was_hit, needs_read, input ready);
  modport sink (input valid, status, slot_out, was_hit, needs_read, output ready);
endinterface

/* sv/hashed_lru_buffer_cache.sv */
// Top level of the hashed LRU buffer cache: request and response channels.
// Depends on hlbc_pkg, hlbc_req_if, hlbc_rsp_if, hlbc_ctrl and hlbc_dpath.
//
// Usage:
//   req carries one item per operation (get, release, pin, unpin); rsp returns exactly
//   one result item per request, in order. Both channels use valid/ready.
//   One request is in work at a time; req.ready is high only while the block is idle.
//   A get first reduces the block number to its bucket (fold, reciprocal multiply,
//   subtract), then walks its bucket list from the head one node a cycle; on a miss
//   it walks bucket lists from the tail, one node a cycle, over its own bucket and
//   then the others. A stolen buffer is moved to the new bucket by link updates.
//   Release, pin and unpin update the slot's count; a release that drops the last
//   reference also moves the buffer by link updates.
//   The result sits in an output register; the next request is taken while it waits,
//   and the block holds a new result until the receiver takes the previous one.
//   Reset (synchronous, active high) clears all tags and counts and restores the
//   initial bucket lists at once, through per-entry valid bits on the link RAMs.
module hashed_lru_buffer_cache import hlbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  hlbc_req_if.sink   req,
  hlbc_rsp_if.source rsp
);

  cmd_t     cmd;
  dp_stat_t stat;
  logic     ready;

  assign req.ready = ready;

  hlbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hlbc_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_func         (req.func),
    .req_device_id    (req.device_id),
    .req_block_number (req.block_number),
    .req_buffer_slot  (req.buffer_slot),
    .rsp              (rsp)
  );

endmodule

/* sv/hlbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hlbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/hlbc_ctrl.sv */
// Controller of the buffer cache: sequences hashing, list walks, moves and result hand-off.
// Depends on hlbc_pkg; drives hlbc_dpath through cmd_t and reads dp_stat_t.
module hlbc_ctrl import hlbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [16:0] {
    S_IDLE       = 17'h00001,
    S_MOD        = 17'h00002,
    S_HIT_START  = 17'h00004,
    S_HIT_WALK   = 17'h00008,
    S_FREE_START = 17'h00010,
    S_FREE_WALK  = 17'h00020,
    S_BKT        = 17'h00040,
    S_MV_RD      = 17'h00080,
    S_DETACH     = 17'h00100,
    S_POS_RD     = 17'h00200,
    S_POS_CAP    = 17'h00400,
    S_REL_POS    = 17'h00800,
    S_INS1       = 17'h01000,
    S_INS2       = 17'h02000,
    S_FILL       = 17'h04000,
    S_SLOT       = 17'h08000,
    S_OUT        = 17'h10000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd        = CMD_LOAD;
          state_next = stat.in_get ? S_MOD : S_SLOT;
        end
      end
      S_MOD: begin
        cmd = CMD_MOD;
        if (stat.mod_last) state_next = S_HIT_START;
      end
      S_HIT_START: begin
        cmd        = CMD_HIT_START;
        state_next = S_HIT_WALK;
      end
      S_HIT_WALK: begin
        if (stat.hit_head) begin
          state_next = S_FREE_START;
        end else if (stat.hit_match) begin
          cmd        = CMD_HIT_DONE;
          state_next = S_OUT;
        end else begin
          cmd = CMD_HIT_STEP;
        end
      end
      S_FREE_START: begin
        cmd        = CMD_FREE_START;
        state_next = S_FREE_WALK;
      end
      S_FREE_WALK: begin
        if (stat.free_head) begin
          cmd        = CMD_BKT_NEXT;
          state_next = S_BKT;
        end else if (stat.free_ok) begin
          cmd        = CMD_FOUND;
          state_next = stat.steal ? S_MV_RD : S_FILL;
        end else begin
          cmd = CMD_FREE_STEP;
        end
      end
      S_BKT: begin
        if (stat.bkt_end) begin
          cmd        = CMD_FAIL;
          state_next = S_OUT;
        end else if (stat.bkt_is_key) begin
          cmd = CMD_BKT_NEXT;
        end else begin
          cmd        = CMD_FREE_START;
          state_next = S_FREE_WALK;
        end
      end
      S_MV_RD: begin
        cmd        = CMD_MV_RD;
        state_next = S_DETACH;
      end
      S_DETACH: begin
        cmd        = CMD_DETACH;
        state_next = stat.is_get ? S_POS_RD : S_REL_POS;
      end
      S_POS_RD: begin
        cmd        = CMD_POS_RD;
        state_next = S_POS_CAP;
      end
      S_POS_CAP: begin
        cmd        = CMD_POS_CAP;
        state_next = S_INS1;
      end
      S_REL_POS: begin
        cmd        = CMD_REL_POS;
        state_next = S_INS1;
      end
      S_INS1: begin
        cmd        = CMD_INS1;
        state_next = S_INS2;
      end
      S_INS2: begin
        cmd        = CMD_INS2;
        state_next = stat.is_get ? S_FILL : S_OUT;
      end
      S_FILL: begin
        cmd        = CMD_FILL;
        state_next = S_OUT;
      end
      S_SLOT: begin
        cmd        = CMD_SLOT;
        state_next = (stat.is_rel && stat.slot_ok && stat.slot_rc_one) ? S_MV_RD : S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

/* sv/hlbc_dpath.sv */
// Datapath of the buffer cache: tag store, reference counts, link RAMs, bucket hash
// and result register. Depends on hlbc_pkg, hlbc_ram and hlbc_rsp_if.
module hlbc_dpath import hlbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  req_func,
  input  logic [7:0]  req_device_id,
  input  logic [31:0] req_block_number,
  input  logic [4:0]  req_buffer_slot,
  hlbc_rsp_if.source  rsp
);

  logic [7:0]       tag_device [NUM_BUFFERS];
  logic [BLK_W-1:0] tag_block  [NUM_BUFFERS];
  key_t             tag_bucket [NUM_BUFFERS];
  logic [7:0]       ref_count  [NUM_BUFFERS];
  logic             data_valid [NUM_BUFFERS];

  logic [1:0]       fn;
  logic [7:0]       dev;
  logic [BLK_W-1:0] blk;
  logic [MOD_W-1:0] mod_sum, mod_rem;
  logic [MOD_Q_W-1:0] mod_q;
  logic [MOD_PROD_W-1:0] mod_prod;
  logic [1:0]       mod_cnt;
  key_t             key;
  bkt_t             bkt;
  logic             steal;
  node_t            found, pos, q;
  logic [1:0]       res_status;
  logic [4:0]       res_slot;
  logic             res_hit, res_nr;

  logic             nxt_we, prv_we;
  node_t            nxt_waddr, nxt_wdata, nxt_raddr, nxt_q, nxt_aq, nxt_d;
  node_t            prv_waddr, prv_wdata, prv_raddr, prv_q, prv_aq, prv_d;
  logic [NODE_COUNT-1:0] nxt_vld, prv_vld;
  logic             nxt_vq, prv_vq;

  node_t            head_bkt, head_key, head_rel;
  slot_t            hit_idx, free_idx, slot_idx, found_idx;
  logic             hit_isbuf, free_isbuf;

  assign head_bkt  = node_t'(NUM_BUFFERS + int'(bkt));
  assign head_key  = node_t'(NUM_BUFFERS + int'(key));
  assign slot_idx  = slot_t'(found);
  assign head_rel  = node_t'(NUM_BUFFERS + int'(tag_bucket[slot_idx]));
  assign found_idx = slot_t'(found);

  assign nxt_d = nxt_vq ? nxt_q : INIT_NEXT[nxt_aq];
  assign prv_d = prv_vq ? prv_q : INIT_PREV[prv_aq];

  assign hit_idx    = nxt_d[SLOT_W-1:0];
  assign free_idx   = prv_d[SLOT_W-1:0];
  assign hit_isbuf  = int'(nxt_d) < NUM_BUFFERS;
  assign free_isbuf = int'(prv_d) < NUM_BUFFERS;

  assign mod_prod = MOD_PROD_W'(mod_sum) * MOD_RECIP;
  assign mod_rem  = mod_sum - (MOD_W'(mod_q) * MOD_W'(NUM_BUCKETS));

  always_comb begin
    stat.in_get      = (req_func == FN_GET);
    stat.is_get      = (fn == FN_GET);
    stat.is_rel      = (fn == FN_REL);
    stat.slot_ok     = int'(found) < NUM_BUFFERS;
    stat.slot_rc_one = (ref_count[slot_idx] == 8'd1);
    stat.mod_last    = (mod_cnt == MOD_LAST);
    stat.hit_head    = (nxt_d == head_bkt);
    stat.hit_match   = hit_isbuf && (tag_device[hit_idx] == dev) && (tag_block[hit_idx] == blk);
    stat.free_head   = (prv_d == head_bkt);
    stat.free_ok     = free_isbuf && (ref_count[free_idx] == 8'd0);
    stat.steal       = steal;
    stat.bkt_end     = int'(bkt) >= NUM_BUCKETS;
    stat.bkt_is_key  = (bkt == {1'b0, key});
    stat.out_free    = !rsp.valid || rsp.ready;
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = '0;
    nxt_raddr = '0;
    prv_we    = 1'b0;
    prv_waddr = '0;
    prv_wdata = '0;
    prv_raddr = '0;
    case (cmd)
      CMD_HIT_START:  nxt_raddr = head_key;
      CMD_HIT_STEP:   nxt_raddr = nxt_d;
      CMD_FREE_START: prv_raddr = head_bkt;
      CMD_FREE_STEP:  prv_raddr = prv_d;
      CMD_MV_RD: begin
        nxt_raddr = found;
        prv_raddr = found;
      end
      CMD_DETACH: begin
        nxt_we    = 1'b1;
        nxt_waddr = prv_d;
        nxt_wdata = nxt_d;
        prv_we    = 1'b1;
        prv_waddr = nxt_d;
        prv_wdata = prv_d;
      end
      CMD_POS_RD:  prv_raddr = head_key;
      CMD_POS_CAP: nxt_raddr = prv_d;
      CMD_REL_POS: nxt_raddr = head_rel;
      CMD_INS1: begin
        nxt_we    = 1'b1;
        nxt_waddr = found;
        nxt_wdata = nxt_d;
        prv_we    = 1'b1;
        prv_waddr = found;
        prv_wdata = pos;
      end
      CMD_INS2: begin
        prv_we    = 1'b1;
        prv_waddr = q;
        prv_wdata = found;
        nxt_we    = 1'b1;
        nxt_waddr = pos;
        nxt_wdata = found;
      end
      default: ;
    endcase
  end

  hlbc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_q)
  );

  hlbc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt_vld <= '0;
      prv_vld <= '0;
    end else begin
      if (nxt_we) nxt_vld[nxt_waddr] <= 1'b1;
      if (prv_we) prv_vld[prv_waddr] <= 1'b1;
    end
    nxt_vq <= nxt_vld[nxt_raddr];
    prv_vq <= prv_vld[prv_raddr];
    nxt_aq <= nxt_raddr;
    prv_aq <= prv_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_device[i] <= '0;
        tag_block[i]  <= '0;
        tag_bucket[i] <= '0;
        ref_count[i]  <= '0;
        data_valid[i] <= 1'b0;
      end
      rsp.valid <= 1'b0;
      steal     <= 1'b0;
    end else begin
      if (cmd == CMD_EMIT) rsp.valid <= 1'b1;
      else if (rsp.ready)  rsp.valid <= 1'b0;
      case (cmd)
        CMD_HIT_START: steal <= 1'b0;
        CMD_HIT_DONE: begin
          if (ref_count[hit_idx] != COUNT_MAX) begin
            ref_count[hit_idx]  <= ref_count[hit_idx] + 8'd1;
            data_valid[hit_idx] <= 1'b1;
          end
        end
        CMD_BKT_NEXT: if (!steal) steal <= 1'b1;
        CMD_FILL: begin
          tag_device[found_idx] <= dev;
          tag_block[found_idx]  <= blk;
          tag_bucket[found_idx] <= key;
          ref_count[found_idx]  <= 8'd1;
          data_valid[found_idx] <= 1'b1;
        end
        CMD_SLOT: begin
          if (stat.slot_ok) begin
            if (fn == FN_PIN) begin
              if (ref_count[slot_idx] != COUNT_MAX)
                ref_count[slot_idx] <= ref_count[slot_idx] + 8'd1;
            end else if (ref_count[slot_idx] != 8'd0) begin
              ref_count[slot_idx] <= ref_count[slot_idx] - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        fn         <= req_func;
        dev        <= req_device_id;
        blk        <= req_block_number;
        mod_cnt    <= '0;
        key        <= '0;
        found      <= node_t'(req_buffer_slot);
        res_status <= ST_OK;
        res_slot   <= '0;
        res_hit    <= 1'b0;
        res_nr     <= 1'b0;
      end
      CMD_MOD: begin
        case (mod_cnt)
          2'd0: mod_sum <= MOD_W'(blk[MOD_FOLD-1:0]) + MOD_W'(blk[2*MOD_FOLD-1:MOD_FOLD]) +
                           MOD_W'(blk[BLK_W-1:2*MOD_FOLD]);
          2'd1: mod_q   <= mod_prod[MOD_PROD_W-1:MOD_SHIFT];
          default: key  <= mod_rem[BKT_W-1:0];
        endcase
        mod_cnt <= mod_cnt + 2'd1;
      end
      CMD_HIT_START: bkt <= {1'b0, key};
      CMD_HIT_DONE: begin
        res_slot <= nxt_d[4:0];
        res_hit  <= 1'b1;
        if (ref_count[hit_idx] == COUNT_MAX) res_status <= ST_SAT;
        else                                 res_nr     <= !data_valid[hit_idx];
      end
      CMD_FOUND: found <= prv_d;
      CMD_BKT_NEXT: bkt <= steal ? bkt + 1'b1 : '0;
      CMD_FAIL: res_status <= ST_NOFREE;
      CMD_POS_CAP: pos <= prv_d;
      CMD_REL_POS: pos <= head_rel;
      CMD_INS1: q <= nxt_d;
      CMD_FILL: begin
        res_slot <= found[4:0];
        res_nr   <= 1'b1;
      end
      CMD_SLOT: begin
        if (stat.slot_ok) begin
          if (fn == FN_PIN) begin
            if (ref_count[slot_idx] == COUNT_MAX) res_status <= ST_SAT;
          end else if (ref_count[slot_idx] == 8'd0) begin
            res_status <= ST_UNDER;
          end
        end
      end
      CMD_EMIT: begin
        rsp.status     <= res_status;
        rsp.slot_out   <= res_slot;
        rsp.was_hit    <= res_hit;
        rsp.needs_read <= res_nr;
      end
      default: ;
    endcase
  end

endmodule
